### rtl/core/dsrm_pkg.sv
// dsrm_pkg: shared types and constants of the drive speed ramp block.
// No dependencies.
package dsrm_pkg;

    localparam int SpeedFractionBits = 4;
    localparam int RegIdxW = 3;
    localparam int ProdW = 56;
    localparam int DivW = 56;
    localparam int DivCntW = 6;

    localparam logic [RegIdxW-1:0] RegRatedVoltage  = 3'd0;
    localparam logic [RegIdxW-1:0] RegRatedCurrent  = 3'd1;
    localparam logic [RegIdxW-1:0] RegRatedFreq     = 3'd2;
    localparam logic [RegIdxW-1:0] RegRatedSpeed    = 3'd3;
    localparam logic [RegIdxW-1:0] RegRampUp        = 3'd4;
    localparam logic [RegIdxW-1:0] RegRampDown      = 3'd5;
    localparam logic [RegIdxW-1:0] RegMaxFreq       = 3'd6;
    localparam logic [RegIdxW-1:0] RegMinFreq       = 3'd7;

    localparam logic [23:0] SpeedMax = 24'd8388607;
    localparam logic [39:0] TempFloor = 40'd2500000;

    typedef logic [ProdW-1:0] prod_t;

endpackage

### rtl/core/dsrm_div.sv
// dsrm_div: bit-serial restoring divider, one quotient bit per cycle.
// Depends on dsrm_pkg.
module dsrm_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [dsrm_pkg::DivW-1:0]     dividend,
    input  logic [dsrm_pkg::DivW-1:0]     divisor,
    output logic                          done,
    output logic [dsrm_pkg::DivW-1:0]     quotient
);

    logic [dsrm_pkg::DivW-1:0]    quo_reg;
    logic [dsrm_pkg::DivW-1:0]    rem_reg;
    logic [dsrm_pkg::DivW-1:0]    dvs_reg;
    logic [dsrm_pkg::DivCntW-1:0] cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [dsrm_pkg::DivW:0]      trial;

    // shift in next dividend bit and try subtract
    assign trial = {rem_reg, quo_reg[dsrm_pkg::DivW-1]} - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                if (!trial[dsrm_pkg::DivW])
                begin
                    rem_reg <= trial[dsrm_pkg::DivW-1:0];
                    quo_reg <= {quo_reg[dsrm_pkg::DivW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[dsrm_pkg::DivW-2:0], quo_reg[dsrm_pkg::DivW-1]};
                    quo_reg <= {quo_reg[dsrm_pkg::DivW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == dsrm_pkg::DivCntW'(dsrm_pkg::DivW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/core/drive_speed_ramp_model.sv
// drive_speed_ramp_model: top level of the V/f drive speed ramp generator.
// Depends on dsrm_pkg and dsrm_div.
//
// Usage: one input transfer (target_frequency, forward) is one 50 ms tick.
// Each tick yields one result transfer with motor_speed, output_frequency,
// motor_current_ma, torque_estimate and temperature.
// Configuration is a separate valid/ready write channel (cfg_index,
// cfg_data); it is always ready and should be used only while idle.
// Six divisions share one bit-serial divider; four products come from a
// shift-add multiplier at one cycle per multiplier bit. The sequencing
// states run them in order, and the divider and the multiplier set the
// time from the input transfer to the load of the result register.
// One item is in flight at a time.
// The result sits in an output register; the next input is accepted the
// cycle after it loads, and its work runs until it needs the output
// register, so a stalled receiver blocks the input after one more item.
// Reset clears speed to 0, temperature to 25 degrees and loads the
// register defaults.
module drive_speed_ramp_model
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [15:0]  target_frequency,
    input  logic         forward,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [23:0]  motor_speed,
    output logic [15:0]  output_frequency,
    output logic [19:0]  motor_current_ma,
    output logic [39:0]  torque_estimate,
    output logic [39:0]  temperature,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_CLAMP, S_M1, S_D1, S_M2, S_D2, S_D3, S_RAMP,
        S_D4, S_D5, S_M3, S_M4, S_D6, S_TEMP, S_OUT
    } state_t;

    state_t state_reg;

    logic [13:0] volt_reg;
    logic [16:0] rcur_reg;
    logic [15:0] rfreq_reg, rup_reg, rdn_reg, fmax_reg, fmin_reg;
    logic [14:0] rspd_reg;

    logic signed [24:0] speed_reg;
    logic [39:0]        temp_reg;

    logic [15:0] f_reg;
    logic        fwd_reg;
    logic [23:0] mag_reg, up_reg, dn_reg, abs_reg;
    logic [19:0] cur_reg;
    logic [15:0] freq_reg;

    // shift-add multiplier: multiplier bits consumed one per cycle
    dsrm_pkg::prod_t mc_reg, mp_reg, acc_reg;
    logic            mbusy_reg;

    logic            dstart_reg;
    dsrm_pkg::prod_t dvd_reg, dvs_reg;
    logic            ddone;
    dsrm_pkg::prod_t dq;
    logic            dwait_reg;

    logic [15:0] rfreq_nz, rup_nz, rdn_nz;
    logic [14:0] rspd_nz;
    dsrm_pkg::prod_t rspd_s, rspd_x5, rspd_x1000;
    logic signed [24:0] tgt, step_up, step_dn;
    logic [40:0] tsum;
    logic        out_load;

    assign rfreq_nz = (rfreq_reg == '0) ? 16'd1 : rfreq_reg;
    assign rspd_nz  = (rspd_reg == '0) ? 15'd1 : rspd_reg;
    assign rup_nz   = (rup_reg == '0) ? 16'd1 : rup_reg;
    assign rdn_nz   = (rdn_reg == '0) ? 16'd1 : rdn_reg;
    assign rspd_s   = dsrm_pkg::ProdW'(rspd_nz) << dsrm_pkg::SpeedFractionBits;
    // constant scalings by shift and add: x5 and x1000 (1024 - 16 - 8)
    assign rspd_x5    = (rspd_s << 2) + rspd_s;
    assign rspd_x1000 = (rspd_s << 10) - (rspd_s << 4) - (rspd_s << 3);

    assign tgt     = fwd_reg ? $signed({1'b0, mag_reg}) : -$signed({1'b0, mag_reg});
    assign step_up = speed_reg + $signed({1'b0, up_reg});
    assign step_dn = speed_reg - $signed({1'b0, dn_reg});
    assign tsum    = {1'b0, temp_reg} + 41'(cur_reg);

    // result register loads this cycle
    assign out_load = !mbusy_reg && !dwait_reg && (state_reg == S_OUT) &&
                      (!out_valid || out_ready);

    dsrm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dstart_reg),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .done     (ddone),
        .quotient (dq)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            volt_reg   <= 14'd4000;
            rcur_reg   <= 17'd10000;
            rfreq_reg  <= 16'd5000;
            rspd_reg   <= 15'd1500;
            rup_reg    <= 16'd200;
            rdn_reg    <= 16'd200;
            fmax_reg   <= 16'd10000;
            fmin_reg   <= 16'd1000;
            speed_reg  <= '0;
            temp_reg   <= dsrm_pkg::TempFloor;
            out_valid  <= 1'b0;
            mbusy_reg  <= 1'b0;
            dstart_reg <= 1'b0;
            dwait_reg  <= 1'b0;
        end
        else
        begin
            // start pulse; the wait flag set with it holds the sequencer off
            if (dstart_reg)
                dstart_reg <= 1'b0;
            if (out_valid && out_ready && !out_load)
                out_valid <= 1'b0;
            if (cfg_valid)
            begin
                case (cfg_index)
                    dsrm_pkg::RegRatedVoltage: volt_reg  <= cfg_data[13:0];
                    dsrm_pkg::RegRatedCurrent: rcur_reg  <= cfg_data[16:0];
                    dsrm_pkg::RegRatedFreq:    rfreq_reg <= cfg_data[15:0];
                    dsrm_pkg::RegRatedSpeed:   rspd_reg  <= cfg_data[14:0];
                    dsrm_pkg::RegRampUp:       rup_reg   <= cfg_data[15:0];
                    dsrm_pkg::RegRampDown:     rdn_reg   <= cfg_data[15:0];
                    dsrm_pkg::RegMaxFreq:      fmax_reg  <= cfg_data[15:0];
                    dsrm_pkg::RegMinFreq:      fmin_reg  <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (mbusy_reg)
            begin
                // one multiplier bit per cycle
                if (mp_reg[0])
                    acc_reg <= acc_reg + mc_reg;
                mc_reg <= mc_reg << 1;
                mp_reg <= mp_reg >> 1;
                if (mp_reg[dsrm_pkg::ProdW-1:1] == '0)
                    mbusy_reg <= 1'b0;
            end
            else if (dwait_reg)
            begin
                if (ddone)
                    dwait_reg <= 1'b0;
            end
            else
            begin
                case (state_reg)
                    S_IDLE:
                    begin
                        if (in_valid)
                        begin
                            f_reg     <= target_frequency;
                            fwd_reg   <= forward;
                            state_reg <= S_CLAMP;
                        end
                    end
                    S_CLAMP:
                    begin
                        if (fmin_reg > fmax_reg || f_reg < fmin_reg)
                            f_reg <= fmin_reg;
                        else if (f_reg > fmax_reg)
                            f_reg <= fmax_reg;
                        state_reg <= S_M1;
                    end
                    S_M1:
                    begin
                        // f * rated_speed * S
                        acc_reg   <= '0;
                        mc_reg    <= rspd_s;
                        mp_reg    <= dsrm_pkg::ProdW'(f_reg);
                        mbusy_reg <= 1'b1;
                        state_reg <= S_D1;
                    end
                    S_D1:
                    begin
                        dvd_reg    <= acc_reg;
                        dvs_reg    <= dsrm_pkg::ProdW'(rfreq_nz);
                        dstart_reg <= 1'b1;
                        dwait_reg  <= 1'b1;
                        state_reg  <= S_M2;
                    end
                    S_M2:
                    begin
                        mag_reg <= (dq > dsrm_pkg::ProdW'(dsrm_pkg::SpeedMax)) ?
                                   dsrm_pkg::SpeedMax : dq[23:0];
                        // up step dividend: rated_speed * 5 * S
                        dvd_reg    <= rspd_x5;
                        dvs_reg    <= dsrm_pkg::ProdW'(rup_nz);
                        dstart_reg <= 1'b1;
                        dwait_reg  <= 1'b1;
                        state_reg  <= S_D2;
                    end
                    S_D2:
                    begin
                        up_reg     <= dq[23:0];
                        dvs_reg    <= dsrm_pkg::ProdW'(rdn_nz);
                        dstart_reg <= 1'b1;
                        dwait_reg  <= 1'b1;
                        state_reg  <= S_D3;
                    end
                    S_D3:
                    begin
                        dn_reg    <= dq[23:0];
                        state_reg <= S_RAMP;
                    end
                    S_RAMP:
                    begin
                        if (speed_reg < tgt)
                            speed_reg <= (step_up > tgt) ? tgt : step_up;
                        else
                            speed_reg <= (step_dn < tgt) ? tgt : step_dn;
                        state_reg <= S_D4;
                    end
                    S_D4:
                    begin
                        abs_reg <= speed_reg[24] ? 24'(-speed_reg) : speed_reg[23:0];
                        acc_reg   <= '0;
                        mc_reg    <= dsrm_pkg::ProdW'(rfreq_nz);
                        mp_reg    <= dsrm_pkg::ProdW'(speed_reg[24] ?
                                     24'(-speed_reg) : speed_reg[23:0]);
                        mbusy_reg <= 1'b1;
                        state_reg <= S_D5;
                    end
                    S_D5:
                    begin
                        dvd_reg    <= acc_reg;
                        dvs_reg    <= rspd_s;
                        dstart_reg <= 1'b1;
                        dwait_reg  <= 1'b1;
                        state_reg  <= S_M3;
                    end
                    S_M3:
                    begin
                        freq_reg  <= (dq > dsrm_pkg::ProdW'(65535)) ? 16'hFFFF : dq[15:0];
                        acc_reg   <= '0;
                        mc_reg    <= dsrm_pkg::ProdW'(rcur_reg);
                        mp_reg    <= dsrm_pkg::ProdW'(abs_reg);
                        mbusy_reg <= 1'b1;
                        state_reg <= S_M4;
                    end
                    S_M4:
                    begin
                        // current dividend in acc; divide, then reuse for torque
                        dvd_reg    <= acc_reg;
                        dvs_reg    <= rspd_s;
                        dstart_reg <= 1'b1;
                        dwait_reg  <= 1'b1;
                        mc_reg     <= acc_reg;
                        state_reg  <= S_D6;
                    end
                    S_D6:
                    begin
                        cur_reg   <= (dq > dsrm_pkg::ProdW'(1048575)) ? 20'hFFFFF : dq[19:0];
                        acc_reg   <= '0;
                        mp_reg    <= dsrm_pkg::ProdW'(volt_reg);
                        mbusy_reg <= 1'b1;
                        state_reg <= S_TEMP;
                    end
                    S_TEMP:
                    begin
                        // rcur*|spd| fits 41 bits, times 14-bit voltage fits 55
                        dvd_reg    <= acc_reg;
                        dvs_reg    <= rspd_x1000;
                        dstart_reg <= 1'b1;
                        dwait_reg  <= 1'b1;
                        if (tsum[40])
                            temp_reg <= '1;
                        else if (tsum[39:0] < dsrm_pkg::TempFloor)
                            temp_reg <= dsrm_pkg::TempFloor;
                        else
                            temp_reg <= tsum[39:0];
                        state_reg <= S_OUT;
                    end
                    S_OUT:
                    begin
                        if (!out_valid || out_ready)
                        begin
                            motor_speed      <= speed_reg[23:0];
                            output_frequency <= freq_reg;
                            motor_current_ma <= cur_reg;
                            torque_estimate  <= (dq[dsrm_pkg::ProdW-1:40] != '0) ?
                                                40'hFF_FFFF_FFFF : dq[39:0];
                            temperature      <= temp_reg;
                            out_valid        <= 1'b1;
                            state_reg        <= S_IDLE;
                        end
                    end
                    default: state_reg <= S_IDLE;
                endcase
            end
        end
    end

endmodule

### tb/tb.sv
// tb: self-checking bench for drive_speed_ramp_model (V/f speed ramp generator).
// Depends on dsrm_pkg and the block RTL; a built-in predictor checks every result transfer.
`timescale 1ns / 100ps

module tb;

    // Field maxima used for saturation
    localparam longint unsigned FreqSat = 64'd65535;
    localparam longint unsigned CurrSat = 64'd1048575;
    localparam longint unsigned Sat40   = 64'hFF_FFFF_FFFF;
    localparam longint unsigned SpdSat  = 64'd8388607;
    localparam longint CycleLimit = 64'd4_000_000;

    typedef struct packed {
        logic [15:0] freq_cmd;
        logic        fwd;
    } tick_t;

    typedef struct packed {
        logic [23:0] spd;
        logic [15:0] freq;
        logic [19:0] cur;
        logic [39:0] torq;
        logic [39:0] temp;
    } drive_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] target_frequency = '0;
    logic        forward = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [23:0] motor_speed;
    logic [15:0] output_frequency;
    logic [19:0] motor_current_ma;
    logic [39:0] torque_estimate;
    logic [39:0] temperature;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    always #5 clk = ~clk;

    drive_speed_ramp_model u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .target_frequency(target_frequency), .forward(forward),
        .out_valid(out_valid), .out_ready(out_ready),
        .motor_speed(motor_speed), .output_frequency(output_frequency),
        .motor_current_ma(motor_current_ma), .torque_estimate(torque_estimate),
        .temperature(temperature),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // ---------------- predictor state ----------------
    longint unsigned drive_reg [8];
    longint          ramp_speed;
    longint unsigned winding_temp;

    tick_t      tick_queue[$];
    drive_out_t expected_outs[$];
    int  mismatches = 0;
    longint cycle_count = 0;
    int  recv_holdoff = 0;      // long receiver stall, cycles remaining
    bit  in_took = 1'b0;        // input transfer at the last rising edge
    bit  out_took = 1'b0;       // result transfer at the last rising edge

    function automatic int reg_width(int idx);
        case (idx)
            dsrm_pkg::RegRatedVoltage: return 14;
            dsrm_pkg::RegRatedCurrent: return 17;
            dsrm_pkg::RegRatedSpeed:   return 15;
            default:                   return 16;
        endcase
    endfunction

    function automatic longint unsigned at_least_one(longint unsigned v);
        return (v == 0) ? 64'd1 : v;
    endfunction

    function automatic longint unsigned clip(longint unsigned v, longint unsigned lim);
        return (v > lim) ? lim : v;
    endfunction

    // One 50 ms tick: advance the ramp and derive all outputs.
    function automatic drive_out_t ramp_tick(tick_t t);
        longint unsigned scale, rfreq, rspd, f, mag, aspd, cur, tsum, rcur, volt;
        longint target, up_step, dn_step, spd;
        drive_out_t o;
        scale = 64'd1 << dsrm_pkg::SpeedFractionBits;
        rfreq = at_least_one(drive_reg[dsrm_pkg::RegRatedFreq]);
        rspd  = at_least_one(drive_reg[dsrm_pkg::RegRatedSpeed]);
        rcur  = drive_reg[dsrm_pkg::RegRatedCurrent];
        volt  = drive_reg[dsrm_pkg::RegRatedVoltage];
        f = t.freq_cmd;
        if (f > drive_reg[dsrm_pkg::RegMaxFreq]) f = drive_reg[dsrm_pkg::RegMaxFreq];
        if (f < drive_reg[dsrm_pkg::RegMinFreq]) f = drive_reg[dsrm_pkg::RegMinFreq];
        mag = clip(f * rspd * scale / rfreq, SpdSat);
        target = t.fwd ? longint'(mag) : -longint'(mag);
        up_step = longint'(rspd * 5 * scale / at_least_one(drive_reg[dsrm_pkg::RegRampUp]));
        dn_step = longint'(rspd * 5 * scale / at_least_one(drive_reg[dsrm_pkg::RegRampDown]));
        spd = ramp_speed;
        if (spd < target)
        begin
            spd += up_step;
            if (spd > target) spd = target;
        end
        else
        begin
            spd -= dn_step;
            if (spd < target) spd = target;
        end
        ramp_speed = spd;
        aspd = longint'((spd < 0) ? -spd : spd);
        cur = clip(rcur * aspd / (rspd * scale), CurrSat);
        o.spd  = spd[23:0];
        o.freq = 16'(clip(aspd * rfreq / (rspd * scale), FreqSat));
        o.cur  = 20'(cur);
        o.torq = 40'(clip(rcur * volt * aspd / (1000 * rspd * scale), Sat40));
        tsum = winding_temp + cur;
        if (tsum > Sat40) tsum = Sat40;
        if (tsum < 64'd2500000) tsum = 64'd2500000;
        winding_temp = tsum;
        o.temp = tsum[39:0];
        return o;
    endfunction

    // Handshakes seen at the rising edge, used by the falling-edge drivers.
    always @(posedge clk)
    begin
        in_took  <= in_valid && in_ready;
        out_took <= out_valid && out_ready;
    end

    // ---------------- driver ----------------
    int send_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_took)
            begin
                expected_outs.push_back(ramp_tick(tick_queue.pop_front()));
                send_gap = $urandom_range(0, 11);
                if ($urandom_range(0, 3) == 0) send_gap = 0;
            end
            if (!in_valid || in_took)
            begin
                if (send_gap > 0 || tick_queue.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (send_gap > 0) send_gap--;
                end
                else
                begin
                    in_valid <= 1'b1;
                    target_frequency <= tick_queue[0].freq_cmd;
                    forward <= tick_queue[0].fwd;
                end
            end
        end
    end

    // ---------------- receiver ready ----------------
    int recv_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_took)
            begin
                recv_gap = $urandom_range(0, 11);
                if ($urandom_range(0, 3) == 0) recv_gap = 0;
            end
            if (recv_holdoff > 0)
            begin
                recv_holdoff--;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin
        drive_out_t exp_o, got;
        cycle_count++;
        if (out_valid && out_ready)
        begin
            got = {motor_speed, output_frequency, motor_current_ma,
                   torque_estimate, temperature};
            if (expected_outs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer: %p", got);
            end
            else
            begin
                exp_o = expected_outs.pop_front();
                if (got !== exp_o)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %p got %p", exp_o, got);
                end
            end
        end
    end

    // Timeout watchdog
    always @(posedge clk)
    begin
        if (cycle_count > CycleLimit)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Register write while idle; the predictor mirrors it at the transfer.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        drive_reg[idx] = val & ((64'd1 << reg_width(idx)) - 1);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_tick(int unsigned f, bit fwd);
        tick_t t;
        t.freq_cmd = f[15:0];
        t.fwd = fwd;
        tick_queue.push_back(t);
    endtask

    // Wait until all ticks are checked, then let the block settle.
    task automatic drain();
        while (tick_queue.size() != 0 || in_valid || expected_outs.size() != 0)
            @(posedge clk);
        repeat (500) @(posedge clk);
    endtask

    task automatic random_regs(bit extreme);
        int unsigned v;
        for (int i = 0; i < 8; i++)
        begin
            if (extreme) v = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
            else v = $urandom;
            // mostly moderate values so ramps reach their targets
            if (!extreme && $urandom_range(0, 2) != 0)
            begin
                case (i)
                    dsrm_pkg::RegRatedSpeed: v = $urandom_range(100, 3000);
                    dsrm_pkg::RegRampUp, dsrm_pkg::RegRampDown: v = $urandom_range(1, 400);
                    dsrm_pkg::RegRatedFreq: v = $urandom_range(1000, 10000);
                    dsrm_pkg::RegMaxFreq: v = $urandom_range(3000, 65535);
                    dsrm_pkg::RegMinFreq: v = $urandom_range(0, 3000);
                    default: v = $urandom_range(0, 1 << reg_width(i));
                endcase
            end
            write_reg(i[2:0], v);
        end
    endtask

    int unsigned fsel;
    initial
    begin
        drive_reg[0] = 4000;  drive_reg[1] = 10000; drive_reg[2] = 5000;
        drive_reg[3] = 1500;  drive_reg[4] = 200;   drive_reg[5] = 200;
        drive_reg[6] = 10000; drive_reg[7] = 1000;
        ramp_speed = 0;
        winding_temp = 64'd2500000;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes and both directions, with defaults
        queue_tick(0, 1); queue_tick(65535, 1); queue_tick(65535, 1);
        queue_tick(5000, 1); queue_tick(5000, 1); queue_tick(65535, 0);
        queue_tick(0, 0); queue_tick(32768, 0); queue_tick(21845, 1);
        drain();
        // Crossed clamps, zero divisors, tiny ramp step
        write_reg(dsrm_pkg::RegMinFreq, 20000);
        write_reg(dsrm_pkg::RegMaxFreq, 100);
        write_reg(dsrm_pkg::RegRatedFreq, 0);
        write_reg(dsrm_pkg::RegRampUp, 65535);
        write_reg(dsrm_pkg::RegRampDown, 0);
        queue_tick(50, 1); queue_tick(60000, 1); queue_tick(1, 0);
        drain();
        // Large target saturates; outputs saturate at full ratings
        write_reg(dsrm_pkg::RegRatedSpeed, 32'hFFFF_FFFF);
        write_reg(dsrm_pkg::RegRatedVoltage, 32'hFFFF_FFFF);
        write_reg(dsrm_pkg::RegRatedCurrent, 32'hFFFF_FFFF);
        write_reg(dsrm_pkg::RegRampUp, 1);
        write_reg(dsrm_pkg::RegRatedFreq, 1);
        write_reg(dsrm_pkg::RegMaxFreq, 65535);
        write_reg(dsrm_pkg::RegMinFreq, 0);
        queue_tick(65535, 1); queue_tick(65535, 1); queue_tick(65535, 0);
        queue_tick(0, 0); queue_tick(65535, 0);
        drain();
        write_reg(dsrm_pkg::RegRatedSpeed, 0);
        write_reg(dsrm_pkg::RegRatedCurrent, 0);
        write_reg(dsrm_pkg::RegRatedVoltage, 0);
        queue_tick(65535, 1); queue_tick(0, 0);
        drain();

        // Random phases; phase 0 also holds the receiver off a long while
        for (int ph = 0; ph < 12; ph++)
        begin
            random_regs(ph == 3 || ph == 8);
            for (int k = 0; k < 120; k++)
            begin
                fsel = $urandom_range(0, 9);
                if (fsel == 0)
                    queue_tick($urandom_range(0, 1) ? 65535 : 0, $urandom_range(0, 1) != 0);
                else
                    queue_tick($urandom_range(0, 65535), ($urandom_range(0, 5) != 0) ^ ph[0]);
            end
            if (ph == 0) recv_holdoff = 6000;
            drain();
        end

        if (mismatches == 0 && expected_outs.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
